/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)

`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

/* rtl/xtkbd_pkg.sv */
// ----------------------------------------------------------------------------
// xtkbd_pkg
// shared types and constants of the xt keyboard byte transmitter
// ----------------------------------------------------------------------------
`default_nettype none

package xtkbd_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INHIBIT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTS_WAIT   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTS_TMO    = 4'd3;

    localparam logic [15:0] RATE_DEFAULT     = 16'd4;
    localparam logic [15:0] SELFTEST_DEFAULT = 16'd1200;
    localparam logic [7:0]  CTS_WAIT_DEFAULT = 8'd6;
    localparam logic [7:0]  CTS_TMO_DEFAULT  = 8'd16;

    localparam logic [3:0] LAST_DATA_BIT = 4'd8;
    localparam logic [3:0] FRAME_END     = 4'd10;
    localparam logic [7:0] TICKS_MAX     = 8'hFF;
    localparam logic [15:0] INHIBIT_MAX  = 16'hFFFF;
    localparam logic [7:0] LOW_TICKS     = 8'd2;
    localparam logic [7:0] RISE_TICKS    = 8'd1;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_WAIT_CTS = 6'b000010,
        PH_CLK_LOW  = 6'b000100,
        PH_CLK_RISE = 6'b001000,
        PH_CLK_HIGH = 6'b010000,
        PH_CLK_FALL = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [15:0] rate_limit_ticks;
        logic [15:0] inhibit_ticks_for_selftest;
        logic [7:0]  cts_min_wait;
        logic [7:0]  cts_timeout;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_index;
        logic [7:0]  phase_ticks;
        logic [7:0]  shift_byte;
        logic [15:0] rate_count;
        logic [15:0] inhibit_count;
        logic        clock_level;
        logic        data_level;
    } state_t;

    typedef struct packed {
        logic clock_drive;
        logic data_drive;
        logic byte_taken;
        logic selftest_request;
    } result_t;

endpackage

`default_nettype wire

/* rtl/xt_keyboard_byte_transmitter.sv */
// ----------------------------------------------------------------------------
// xt_keyboard_byte_transmitter
// device side of an xt keyboard link, one result per sampled tick
// ----------------------------------------------------------------------------
// Each input item is one sampled tick of the host clock and data lines plus
// the byte offer; each yields exactly one result with the line drives and the
// byte-taken and self-test strobes. One item is accepted every clock cycle
// while in_stall is low; an item passes an input register and the state
// update into a result register, from which its result is offered. A stalled
// result holds the input register, and the input side stalls only when both
// are full. The user must write configuration through cfg_write only while no
// item is in flight; the block itself does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module xt_keyboard_byte_transmitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [xtkbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xtkbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             clock_line,
    input  logic                             data_line,
    input  logic                             byte_ready,
    input  logic [7:0]                       next_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             clock_drive,
    output logic                             data_drive,
    output logic                             byte_taken,
    output logic                             selftest_request
);
    import xtkbd_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;

    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       clock_line_reg;
    logic       data_line_reg;
    logic       byte_ready_reg;
    logic [7:0] next_byte_reg;
    logic       in_accept;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_limit_ticks           <= RATE_DEFAULT;
            cfg_reg.inhibit_ticks_for_selftest <= SELFTEST_DEFAULT;
            cfg_reg.cts_min_wait               <= CTS_WAIT_DEFAULT;
            cfg_reg.cts_timeout                <= CTS_TMO_DEFAULT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RATE_LIMIT: cfg_reg.rate_limit_ticks           <= cfg_data;
                CFG_INHIBIT:    cfg_reg.inhibit_ticks_for_selftest <= cfg_data;
                CFG_CTS_WAIT:   cfg_reg.cts_min_wait               <= cfg_data[7:0];
                CFG_CTS_TMO:    cfg_reg.cts_timeout                <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // handshake and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.phase         <= PH_IDLE;
            state_reg.bit_index     <= 4'd0;
            state_reg.phase_ticks   <= 8'd0;
            state_reg.shift_byte    <= 8'd0;
            state_reg.rate_count    <= 16'd0;
            state_reg.inhibit_count <= 16'd0;
            state_reg.clock_level   <= 1'b1;
            state_reg.data_level    <= 1'b1;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            clock_line_reg <= clock_line;
            data_line_reg  <= data_line;
            byte_ready_reg <= byte_ready;
            next_byte_reg  <= next_byte;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    xtkbd_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .clock_line (clock_line_reg),
        .data_line  (data_line_reg),
        .byte_ready (byte_ready_reg),
        .next_byte  (next_byte_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    assign out_valid        = out_valid_reg;
    assign clock_drive      = res_reg.clock_drive;
    assign data_drive       = res_reg.data_drive;
    assign byte_taken       = res_reg.byte_taken;
    assign selftest_request = res_reg.selftest_request;

    `ASSERT_CLK(a_no_lost_item, clk, rst_n, in_valid_reg && !advance |=> in_valid_reg, "item dropped")
    `ASSERT_NEVER(a_bit_index_range, clk, rst_n, state_reg.bit_index > FRAME_END, "bit index overrun")
    `ASSERT_CLK(a_cts_clock_low, clk, rst_n, state_reg.phase == PH_WAIT_CTS |-> !state_reg.clock_level, "clock released in wait")
    `ASSERT_CLK(a_taken_data_high, clk, rst_n, out_valid_reg && res_reg.byte_taken |-> res_reg.data_drive && !res_reg.selftest_request, "bad end of frame")

endmodule

`default_nettype wire

/* rtl/xtkbd_step.sv */
// ----------------------------------------------------------------------------
// xtkbd_step
// next state and result of the transmitter for one sampled tick
// ----------------------------------------------------------------------------
`default_nettype none

module xtkbd_step (
    input  xtkbd_pkg::state_t  cur,
    input  xtkbd_pkg::cfg_t    cfg,
    input  logic               clock_line,
    input  logic               data_line,
    input  logic               byte_ready,
    input  logic [7:0]         next_byte,
    output xtkbd_pkg::state_t  nxt,
    output xtkbd_pkg::result_t res
);
    import xtkbd_pkg::*;

    logic [7:0]  ticks_up;
    logic [15:0] rate_dec;
    logic [15:0] inhibit_up;
    logic        taken;
    logic        selftest;

    assign ticks_up   = (cur.phase_ticks != TICKS_MAX) ? cur.phase_ticks + 8'd1
                                                       : cur.phase_ticks;
    assign rate_dec   = (cur.rate_count != 16'd0) ? cur.rate_count - 16'd1 : 16'd0;
    assign inhibit_up = cur.inhibit_count + 16'd1;

    always_comb
    begin
        nxt      = cur;
        taken    = 1'b0;
        selftest = 1'b0;
        case (cur.phase)
            PH_WAIT_CTS:
            begin
                nxt.phase_ticks = ticks_up;
                if (ticks_up >= cfg.cts_min_wait && data_line)
                begin
                    nxt.phase       = PH_CLK_LOW;
                    nxt.phase_ticks = 8'd0;
                end
                else if (ticks_up >= cfg.cts_timeout)
                begin
                    nxt.clock_level   = 1'b1;
                    nxt.data_level    = 1'b1;
                    nxt.phase_ticks   = 8'd0;
                    nxt.inhibit_count = 16'd0;
                    nxt.phase         = PH_IDLE;
                end
            end
            PH_CLK_LOW:
            begin
                nxt.phase_ticks = ticks_up;
                if (ticks_up == LOW_TICKS)
                begin
                    if (cur.bit_index == 4'd0)
                    begin
                        nxt.data_level = 1'b1;
                    end
                    else if (cur.bit_index <= LAST_DATA_BIT)
                    begin
                        nxt.data_level = cur.shift_byte[0];
                        nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
                    end
                    nxt.bit_index   = cur.bit_index + 4'd1;
                    nxt.phase       = PH_CLK_RISE;
                    nxt.phase_ticks = 8'd0;
                    nxt.clock_level = 1'b1;
                end
            end
            PH_CLK_RISE:
            begin
                nxt.phase_ticks = ticks_up;
                if (ticks_up == RISE_TICKS)
                begin
                    nxt.clock_level = 1'b1;
                end
                else
                begin
                    nxt.phase = PH_CLK_HIGH;
                end
            end
            PH_CLK_HIGH:
            begin
                if (cur.bit_index == FRAME_END)
                begin
                    nxt.bit_index     = 4'd0;
                    taken             = 1'b1;
                    nxt.data_level    = 1'b1;
                    nxt.phase         = PH_IDLE;
                    nxt.inhibit_count = 16'd0;
                end
                else
                begin
                    nxt.phase = PH_CLK_FALL;
                end
            end
            PH_CLK_FALL:
            begin
                nxt.clock_level = 1'b0;
                nxt.phase       = PH_CLK_LOW;
                nxt.phase_ticks = 8'd0;
            end
            default:
            begin
                nxt.phase = PH_IDLE;
                if (clock_line)
                begin
                    nxt.rate_count = rate_dec;
                    if (rate_dec == 16'd0 && byte_ready)
                    begin
                        nxt.rate_count  = cfg.rate_limit_ticks;
                        nxt.shift_byte  = next_byte;
                        nxt.phase_ticks = 8'd0;
                        if (data_line)
                        begin
                            nxt.phase = PH_CLK_LOW;
                        end
                        else
                        begin
                            nxt.clock_level = 1'b0;
                            nxt.phase       = PH_WAIT_CTS;
                        end
                    end
                    nxt.inhibit_count = 16'd0;
                end
                else if (cur.inhibit_count != INHIBIT_MAX)
                begin
                    nxt.inhibit_count = inhibit_up;
                    selftest          = (inhibit_up == cfg.inhibit_ticks_for_selftest);
                end
            end
        endcase
    end

    assign res.clock_drive      = nxt.clock_level;
    assign res.data_drive       = nxt.data_level;
    assign res.byte_taken       = taken;
    assign res.selftest_request = selftest;

endmodule

`default_nettype wire
